// File: design/rsid_pkg.sv
// Shared constants for the ray-sphere intersection distance block.
`default_nettype none

package rsid_pkg;

    // Parameter defaults
    localparam int CW_DEFAULT       = 32;
    localparam int DIR_FRAC_DEFAULT = 30;

    // Fixed field widths
    localparam int DIR_W    = 32;
    localparam int RADIUS_W = 31;
    localparam int TOL_W    = 32;
    localparam int DIST_W   = 34;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register index, taken from paddr[2]
    localparam logic REG_RADIUS    = 1'b0;
    localparam logic REG_TOLERANCE = 1'b1;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(65536);
    localparam logic [TOL_W-1:0]    TOL_RESET    = TOL_W'(64);

endpackage

`default_nettype wire

// File: design/rsid_mul.sv
// Two-stage signed multiplier built from four half-width partial products.
`default_nettype none

module rsid_mul #(
    parameter int A_W = 32,
    parameter int B_W = 32
) (
    input  wire                      aclk,
    input  wire  [1:0]               ce,
    input  wire  signed [A_W-1:0]    a,
    input  wire  signed [B_W-1:0]    b,
    output logic signed [A_W+B_W-1:0] p
);

    localparam int A_LO = A_W / 2;
    localparam int A_HI = A_W - A_LO;
    localparam int B_LO = B_W / 2;
    localparam int B_HI = B_W - B_LO;
    localparam int P_W  = A_W + B_W;

    logic signed [A_HI-1:0] a_hi;
    logic        [A_LO-1:0] a_lo;
    logic signed [B_HI-1:0] b_hi;
    logic        [B_LO-1:0] b_lo;

    logic signed [A_HI+B_HI-1:0] hh_reg;
    logic signed [A_HI+B_LO:0]   hl_reg;
    logic signed [A_LO+B_HI:0]   lh_reg;
    logic        [A_LO+B_LO-1:0] ll_reg;
    logic signed [P_W-1:0]       p_reg;
    logic signed [P_W-1:0]       p_next;

    assign a_hi = a[A_W-1:A_LO];
    assign a_lo = a[A_LO-1:0];
    assign b_hi = b[B_W-1:B_LO];
    assign b_lo = b[B_LO-1:0];

    // recombine partials: high parts carry the sign, low parts are unsigned
    assign p_next = (P_W'(hh_reg) <<< (A_LO + B_LO))
                  + (P_W'(hl_reg) <<< A_LO)
                  + (P_W'(lh_reg) <<< B_LO)
                  + P_W'(ll_reg);

    always_ff @(posedge aclk) begin
        if (ce[0]) begin
            hh_reg <= a_hi * b_hi;
            hl_reg <= a_hi * $signed({1'b0, b_lo});
            lh_reg <= $signed({1'b0, a_lo}) * b_hi;
            ll_reg <= a_lo * b_lo;
        end
        if (ce[1]) begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// File: design/rsid_sqrt.sv
// Pipelined integer square root, one result bit per stage, with a side tag.
`default_nettype none

module rsid_sqrt #(
    parameter int ROOT_W = 37,
    parameter int TAG_W  = 38
) (
    input  wire                 aclk,
    input  wire  [ROOT_W-1:0]   ce,
    input  wire  [2*ROOT_W-1:0] rad,
    input  wire  [TAG_W-1:0]    tag_in,
    output logic [ROOT_W-1:0]   root,
    output logic [TAG_W-1:0]    tag_out
);

    logic [2*ROOT_W-1:0] rad_reg  [ROOT_W-1];
    logic [ROOT_W-1:0]   rem_reg  [ROOT_W-1];
    logic [ROOT_W-1:0]   root_reg [ROOT_W];
    logic [TAG_W-1:0]    tag_reg  [ROOT_W];

    logic [2*ROOT_W-1:0] rad_src  [ROOT_W];
    logic [ROOT_W-1:0]   rem_src  [ROOT_W];
    logic [ROOT_W-1:0]   root_src [ROOT_W];
    logic [TAG_W-1:0]    tag_src  [ROOT_W];
    logic [ROOT_W+1:0]   rem_cat  [ROOT_W];
    logic [ROOT_W+1:0]   trial    [ROOT_W];
    logic [ROOT_W+1:0]   diff     [ROOT_W];
    logic [ROOT_W-1:0]   rem_next [ROOT_W];
    logic [ROOT_W-1:0]   root_next[ROOT_W];
    logic                take     [ROOT_W];

    always_comb begin
        for (int k = 0; k < ROOT_W; k++) begin
            if (k == 0) begin
                rad_src[k]  = rad;
                rem_src[k]  = '0;
                root_src[k] = '0;
                tag_src[k]  = tag_in;
            end else begin
                rad_src[k]  = rad_reg[k-1];
                rem_src[k]  = rem_reg[k-1];
                root_src[k] = root_reg[k-1];
                tag_src[k]  = tag_reg[k-1];
            end
            // bring down the next two radicand bits, try root*4+1
            rem_cat[k]   = {rem_src[k], rad_src[k][2*ROOT_W-1 -: 2]};
            trial[k]     = {root_src[k], 2'b01};
            take[k]      = rem_cat[k] >= trial[k];
            diff[k]      = rem_cat[k] - trial[k];
            rem_next[k]  = take[k] ? diff[k][ROOT_W-1:0] : rem_cat[k][ROOT_W-1:0];
            root_next[k] = {root_src[k][ROOT_W-2:0], take[k]};
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < ROOT_W; k++) begin
            if (ce[k]) begin
                root_reg[k] <= root_next[k];
                tag_reg[k]  <= tag_src[k];
            end
        end
        for (int k = 0; k < ROOT_W - 1; k++) begin
            if (ce[k]) begin
                rad_reg[k] <= {rad_src[k][2*ROOT_W-3:0], 2'b00};
                rem_reg[k] <= rem_next[k];
            end
        end
    end

    assign root    = root_reg[ROOT_W-1];
    assign tag_out = tag_reg[ROOT_W-1];

endmodule

`default_nettype wire

// File: design/ray_sphere_intersect_distance.sv
// Top level of the ray-sphere intersection distance pipeline.
//
//  channel  direction  handshake            word
//  s_       in         s_valid / s_ready    ray origin (x,y,z) and direction (x,y,z)
//  m_       out        m_valid / m_ready    hit flag and Q18.16 distance
//  apb      in/out     psel, penable, ...   sphere_radius at 0x0, surface_tolerance at 0x4
//
// One ray enters per cycle while s_ready is high; each word passes through the
// fixed stages and S_W square root stages (37 at the default widths, one root
// bit per stage) to the output register. Reset clears all valid bits;
// the configuration registers return to radius 1.0 and tolerance 64.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles collapse under a stalled output and s_ready stays high while any
// stage is free.
`default_nettype none

module ray_sphere_intersect_distance
    import rsid_pkg::*;
#(
    parameter int COORD_WIDTH   = CW_DEFAULT,
    parameter int DIR_FRAC_BITS = DIR_FRAC_DEFAULT
) (
    input  wire                          aclk,
    input  wire                          aresetn,

    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  signed [COORD_WIDTH-1:0] s_origin_x,
    input  wire  signed [COORD_WIDTH-1:0] s_origin_y,
    input  wire  signed [COORD_WIDTH-1:0] s_origin_z,
    input  wire  signed [DIR_W-1:0]       s_dir_x,
    input  wire  signed [DIR_W-1:0]       s_dir_y,
    input  wire  signed [DIR_W-1:0]       s_dir_z,

    output logic                         m_valid,
    input  wire                          m_ready,
    output logic                         m_hit,
    output logic [DIST_W-1:0]            m_distance,

    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [APB_ADDR_W-1:0]        paddr,
    input  wire  [APB_DATA_W-1:0]        pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready
);

    // ------------------------------------------------------------------
    // Widths. Squares and dot products are kept exact; b is rounded to
    // Q.16 before it is squared, so d and the root are exact integers.
    // ------------------------------------------------------------------
    localparam int CW     = COORD_WIDTH;
    localparam int DF     = DIR_FRAC_BITS;
    localparam int SQP_W  = 2 * CW;                 // one origin square
    localparam int RR_W   = 2 * (RADIUS_W + 1);     // radius square
    localparam int BP_W   = CW + DIR_W;             // one dot product term
    localparam int PP_W   = 2 * CW + 2;             // |p|^2
    localparam int C_W    = ((PP_W > RR_W) ? PP_W : RR_W) + 1;
    localparam int B_W    = BP_W + 2;               // p.n, full precision
    localparam int B16_W  = B_W + 1 - DF;           // p.n rounded to Q.16
    localparam int SQ_W   = 2 * B16_W;
    localparam int D_W    = ((SQ_W > C_W) ? SQ_W : C_W) + 1;
    localparam int S_W    = D_W / 2;                // root bits
    localparam int N_W    = 2 * S_W;                // radicand bits
    localparam int R_W    = ((B16_W > S_W) ? B16_W : S_W) + 2;
    localparam int TAG_W  = B16_W + 1;

    // stage numbers
    localparam int ST_PART  = 0;                    // multiplier partials
    localparam int ST_PROD  = 1;                    // products
    localparam int ST_SUM   = 2;                    // |p|^2, p.n
    localparam int ST_C     = 3;                    // c, b16
    localparam int ST_SQP   = 4;                    // surface test, b16^2 partials
    localparam int ST_SQ    = 5;                    // b16^2
    localparam int ST_D     = 6;                    // d, miss
    localparam int ST_ROOT0 = 7;                    // first root stage
    localparam int ST_RT    = ST_ROOT0 + S_W;       // both roots
    localparam int ST_OUT   = ST_RT + 1;            // output register
    localparam int N_ST     = ST_OUT + 1;

    localparam logic signed [B_W:0] HALF_ULP = (B_W + 1)'(1) <<< (DF - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [RADIUS_W-1:0] sphere_radius_reg;
    logic [TOL_W-1:0]    surface_tolerance_reg;
    logic                cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sphere_radius_reg     <= RADIUS_RESET;
            surface_tolerance_reg <= TOL_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_RADIUS:    sphere_radius_reg     <= pwdata[RADIUS_W-1:0];
                REG_TOLERANCE: surface_tolerance_reg <= pwdata[TOL_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_RADIUS:    prdata = APB_DATA_W'(sphere_radius_reg);
            REG_TOLERANCE: prdata = APB_DATA_W'(surface_tolerance_reg);
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Stage valid bits and advance enables.
    // A stage loads when it is empty or some stage ahead of it is empty,
    // or the output word is being taken.
    // ------------------------------------------------------------------
    logic [N_ST-1:0] vld_reg;
    logic [N_ST-1:0] vld_next;
    logic [N_ST-1:0] ce;

    always_comb begin
        for (int i = 0; i < N_ST; i++) begin
            ce[i] = m_ready | (|(~vld_reg & ({N_ST{1'b1}} << i)));
        end
    end

    assign vld_next = {vld_reg[N_ST-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < N_ST; i++) begin
                if (ce[i]) begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    assign s_ready = ce[ST_PART];
    assign m_valid = vld_reg[ST_OUT];

    // ------------------------------------------------------------------
    // Stages 0-1: seven products in parallel
    // ------------------------------------------------------------------
    logic signed [SQP_W-1:0] sq_x, sq_y, sq_z;
    logic signed [BP_W-1:0]  bp_x, bp_y, bp_z;
    logic signed [RR_W-1:0]  rr;

    rsid_mul #(.A_W(CW), .B_W(CW)) u_mul_sqx (
        .aclk(aclk), .ce(ce[ST_PART +: 2]), .a(s_origin_x), .b(s_origin_x), .p(sq_x)
    );
    rsid_mul #(.A_W(CW), .B_W(CW)) u_mul_sqy (
        .aclk(aclk), .ce(ce[ST_PART +: 2]), .a(s_origin_y), .b(s_origin_y), .p(sq_y)
    );
    rsid_mul #(.A_W(CW), .B_W(CW)) u_mul_sqz (
        .aclk(aclk), .ce(ce[ST_PART +: 2]), .a(s_origin_z), .b(s_origin_z), .p(sq_z)
    );
    rsid_mul #(.A_W(CW), .B_W(DIR_W)) u_mul_bx (
        .aclk(aclk), .ce(ce[ST_PART +: 2]), .a(s_origin_x), .b(s_dir_x), .p(bp_x)
    );
    rsid_mul #(.A_W(CW), .B_W(DIR_W)) u_mul_by (
        .aclk(aclk), .ce(ce[ST_PART +: 2]), .a(s_origin_y), .b(s_dir_y), .p(bp_y)
    );
    rsid_mul #(.A_W(CW), .B_W(DIR_W)) u_mul_bz (
        .aclk(aclk), .ce(ce[ST_PART +: 2]), .a(s_origin_z), .b(s_dir_z), .p(bp_z)
    );
    // user keeps radius stable while words are in flight (block does not enforce it); square it alongside
    rsid_mul #(.A_W(RADIUS_W + 1), .B_W(RADIUS_W + 1)) u_mul_rr (
        .aclk(aclk), .ce(ce[ST_PART +: 2]),
        .a($signed({1'b0, sphere_radius_reg})), .b($signed({1'b0, sphere_radius_reg})),
        .p(rr)
    );

    // ------------------------------------------------------------------
    // Stage 2: |p|^2 and p.n
    // ------------------------------------------------------------------
    logic signed [PP_W-1:0] pp_reg;
    logic signed [B_W-1:0]  bsum_reg;
    logic signed [RR_W-1:0] rr2_reg;

    always_ff @(posedge aclk) begin
        if (ce[ST_SUM]) begin
            pp_reg   <= PP_W'(sq_x) + PP_W'(sq_y) + PP_W'(sq_z);
            bsum_reg <= B_W'(bp_x) + B_W'(bp_y) + B_W'(bp_z);
            rr2_reg  <= rr;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: c = |p|^2 - R^2, b rounded half up to Q.16
    // ------------------------------------------------------------------
    logic signed [C_W-1:0]   c3_reg;
    logic signed [B16_W-1:0] b16_3_reg;
    logic signed [B_W:0]     bround;

    assign bround = (B_W + 1)'(bsum_reg) + HALF_ULP;

    always_ff @(posedge aclk) begin
        if (ce[ST_C]) begin
            c3_reg    <= C_W'(pp_reg) - C_W'(rr2_reg);
            b16_3_reg <= bround[B_W:DF];
        end
    end

    // ------------------------------------------------------------------
    // Stages 4-5: surface test, b16^2
    // ------------------------------------------------------------------
    logic signed [C_W-1:0]   tol_s;
    logic                    surf4_reg, surf5_reg;
    logic signed [C_W-1:0]   c4_reg, c5_reg;
    logic signed [B16_W-1:0] b16_4_reg, b16_5_reg;
    logic signed [SQ_W-1:0]  bsq;

    assign tol_s = $signed(C_W'(surface_tolerance_reg));

    rsid_mul #(.A_W(B16_W), .B_W(B16_W)) u_mul_bsq (
        .aclk(aclk), .ce(ce[ST_SQP +: 2]), .a(b16_3_reg), .b(b16_3_reg), .p(bsq)
    );

    always_ff @(posedge aclk) begin
        if (ce[ST_SQP]) begin
            // origin on the sphere: |c| within tolerance
            surf4_reg <= (c3_reg <= tol_s) && (c3_reg >= -tol_s);
            c4_reg    <= c3_reg;
            b16_4_reg <= b16_3_reg;
        end
        if (ce[ST_SQ]) begin
            surf5_reg <= surf4_reg;
            c5_reg    <= c4_reg;
            b16_5_reg <= b16_4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: discriminant; a negative one, or an origin on the shell, is a miss
    // ------------------------------------------------------------------
    logic signed [D_W-1:0]   d;
    logic                    miss6_reg;
    logic [D_W-2:0]          n6_reg;
    logic signed [B16_W-1:0] b16_6_reg;

    assign d = D_W'(bsq) - D_W'(c5_reg);

    always_ff @(posedge aclk) begin
        if (ce[ST_D]) begin
            miss6_reg <= surf5_reg | d[D_W-1];
            n6_reg    <= d[D_W-2:0];
            b16_6_reg <= b16_5_reg;
        end
    end

    // ------------------------------------------------------------------
    // Square root stages; miss flag and b16 ride along as the tag
    // ------------------------------------------------------------------
    logic [S_W-1:0]   root;
    logic [TAG_W-1:0] tag_rt;

    rsid_sqrt #(.ROOT_W(S_W), .TAG_W(TAG_W)) u_sqrt (
        .aclk    (aclk),
        .ce      (ce[ST_ROOT0 +: S_W]),
        .rad     (N_W'(n6_reg)),
        .tag_in  ({miss6_reg, b16_6_reg}),
        .root    (root),
        .tag_out (tag_rt)
    );

    // ------------------------------------------------------------------
    // Roots: r1 = -b + s, r2 = -b - s
    // ------------------------------------------------------------------
    logic signed [R_W-1:0] s_ext, b_ext;
    logic signed [R_W-1:0] r1_reg, r2_reg;
    logic                  miss_rt_reg;

    assign s_ext = R_W'(root);
    assign b_ext = R_W'($signed(tag_rt[B16_W-1:0]));

    always_ff @(posedge aclk) begin
        if (ce[ST_RT]) begin
            r1_reg      <= s_ext - b_ext;
            r2_reg      <= -b_ext - s_ext;
            miss_rt_reg <= tag_rt[B16_W];
        end
    end

    // ------------------------------------------------------------------
    // Output register: nearest positive root, saturated to Q18.16
    // ------------------------------------------------------------------
    logic                  pos1, pos2;
    logic signed [R_W-1:0] t_sel;
    logic                  sat;
    logic                  hit_next;
    logic [DIST_W-1:0]     dist_next;
    logic                  hit_reg;
    logic [DIST_W-1:0]     dist_reg;

    always_comb begin
        pos1      = !r1_reg[R_W-1] && (|r1_reg);
        pos2      = !r2_reg[R_W-1] && (|r2_reg);
        t_sel     = pos2 ? r2_reg : r1_reg;
        sat       = |t_sel[R_W-2:DIST_W];
        hit_next  = !miss_rt_reg && (pos1 || pos2);
        if (!hit_next) begin
            dist_next = '0;
        end else if (sat) begin
            dist_next = '1;
        end else begin
            dist_next = t_sel[DIST_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce[ST_OUT]) begin
            hit_reg  <= hit_next;
            dist_reg <= dist_next;
        end
    end

    assign m_hit      = hit_reg;
    assign m_distance = dist_reg;

endmodule

`default_nettype wire

// File: bench/tb_ray_sphere_intersect_distance.sv
// Self-checking testbench for the ray-sphere intersection distance pipeline.
`timescale 1ns / 100ps

module tb_ray_sphere_intersect_distance;
    import rsid_pkg::*;

    localparam int CW             = CW_DEFAULT;
    localparam int DIR_FRAC       = DIR_FRAC_DEFAULT;
    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 10;
    // 9 fixed stages plus 37 square root stages at the default widths
    localparam int PIPE_LATENCY   = 46;
    localparam int RAYS_PER_PHASE = 300;
    localparam int NUM_PHASES     = 6;
    // Watchdog bound for the whole run
    localparam int TIMEOUT_CYCLES = 600000;

    // Wide enough for every product and sum the intersection math produces
    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic [CW-1:0]    ox;
        logic [CW-1:0]    oy;
        logic [CW-1:0]    oz;
        logic [DIR_W-1:0] dx;
        logic [DIR_W-1:0] dy;
        logic [DIR_W-1:0] dz;
    } ray_t;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] distance;
    } hit_t;

    typedef struct packed {
        ray_t ray;
        logic known;    // expected word typed in below, else taken from the predictor
        hit_t want;
    } row_t;

    typedef enum int {RX_OPEN, RX_BUSY, RX_SPARSE, RX_PERIODIC, RX_BLOCKED} rx_mode_t;

    localparam logic [APB_ADDR_W-1:0] ADDR_RADIUS    = {REG_RADIUS, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_TOLERANCE = {REG_TOLERANCE, 2'b00};

    localparam wide_t ROUND_HALF = wide_t'(1) << (DIR_FRAC - 1);
    localparam wide_t DIST_CAP   = {{(128 - DIST_W){1'b0}}, {DIST_W{1'b1}}};

    // Handy Q16.16 origins and Q2.30 directions
    localparam logic [31:0] ZERO   = 32'h0000_0000;
    localparam logic [31:0] P_ONE  = 32'h0001_0000;
    localparam logic [31:0] P_HALF = 32'h0000_8000;
    localparam logic [31:0] P_TWO  = 32'h0002_0000;
    localparam logic [31:0] P_M1   = 32'hFFFF_0000;
    localparam logic [31:0] P_M2   = 32'hFFFE_0000;
    localparam logic [31:0] P_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] P_MIN  = 32'h8000_0000;
    localparam logic [31:0] D_ONE  = 32'h4000_0000;
    localparam logic [31:0] D_NEG  = 32'hC000_0000;
    localparam logic [31:0] D_HALF = 32'h2000_0000;
    localparam logic [31:0] ALL1   = 32'hFFFF_FFFF;

    localparam hit_t NO_HIT = '0;

    // Directed rays, all run with the reset radius of 1.0 and tolerance of 64
    localparam int N_DIRECTED = 19;
    row_t directed_rows [N_DIRECTED] = '{
        // start at the center, every direction reaches the shell at 1.0
        '{'{ZERO, ZERO, ZERO, D_ONE, ZERO, ZERO}, 1'b1, '{1'b1, DIST_W'(65536)}},
        '{'{ZERO, ZERO, ZERO, ZERO, ZERO, ZERO}, 1'b1, '{1'b1, DIST_W'(65536)}},
        '{'{ZERO, ZERO, ZERO, D_NEG, ZERO, ZERO}, 1'b1, '{1'b1, DIST_W'(65536)}},
        // outside at x=2, toward and away from the sphere
        '{'{P_TWO, ZERO, ZERO, D_NEG, ZERO, ZERO}, 1'b1, '{1'b1, DIST_W'(65536)}},
        '{'{P_TWO, ZERO, ZERO, D_ONE, ZERO, ZERO}, 1'b1, NO_HIT},
        // origin exactly on the shell
        '{'{P_ONE, ZERO, ZERO, D_NEG, ZERO, ZERO}, 1'b1, NO_HIT},
        '{'{ZERO, ZERO, P_M1, ZERO, ZERO, D_ONE}, 1'b1, NO_HIT},
        // shell error of exactly the tolerance, then one lsb past it
        '{'{P_ONE, 32'd8, ZERO, D_NEG, ZERO, ZERO}, 1'b1, NO_HIT},
        '{'{P_ONE, 32'd8, 32'd1, D_NEG, ZERO, ZERO}, 1'b1, '{1'b1, DIST_W'(1)}},
        // grazing ray, zero discriminant
        '{'{P_M2, P_ONE, ZERO, D_ONE, ZERO, ZERO}, 1'b1, '{1'b1, DIST_W'(131072)}},
        // passes beside the sphere, negative discriminant
        '{'{P_TWO, P_TWO, ZERO, ZERO, ZERO, D_ONE}, 1'b1, NO_HIT},
        // inside, only the far root is ahead
        '{'{P_HALF, ZERO, ZERO, D_ONE, ZERO, ZERO}, 1'b1, '{1'b1, DIST_W'(32768)}},
        // coordinate and direction extremes
        '{'{P_MAX, P_MAX, P_MAX, D_NEG, D_NEG, D_NEG}, 1'b0, NO_HIT},
        '{'{P_MIN, P_MIN, P_MIN, D_ONE, D_ONE, D_ONE}, 1'b0, NO_HIT},
        '{'{P_MIN, P_MAX, ZERO, D_ONE, D_NEG, D_ONE}, 1'b0, NO_HIT},
        // dot product lands exactly on a half lsb, both signs
        '{'{32'd1, ZERO, ZERO, D_HALF, ZERO, ZERO}, 1'b0, NO_HIT},
        '{'{ALL1, ZERO, ZERO, D_HALF, ZERO, ZERO}, 1'b0, NO_HIT},
        // short direction vector, used as given
        '{'{ZERO, 32'h0003_0000, ZERO, ZERO, 32'hE000_0000, ZERO}, 1'b0, NO_HIT},
        '{'{ALL1, ZERO, 32'd1, ALL1, ZERO, ALL1}, 1'b0, NO_HIT}
    };

    logic                  aclk       = 1'b0;
    logic                  aresetn    = 1'b0;
    logic                  s_valid    = 1'b0;
    logic                  s_ready;
    logic [CW-1:0]         s_origin_x = '0;
    logic [CW-1:0]         s_origin_y = '0;
    logic [CW-1:0]         s_origin_z = '0;
    logic [DIR_W-1:0]      s_dir_x    = '0;
    logic [DIR_W-1:0]      s_dir_y    = '0;
    logic [DIR_W-1:0]      s_dir_z    = '0;
    logic                  m_valid;
    logic                  m_ready    = 1'b0;
    logic                  m_hit;
    logic [DIST_W-1:0]     m_distance;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [APB_ADDR_W-1:0] paddr      = '0;
    logic [APB_DATA_W-1:0] pwdata     = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Expected words in arrival order, one per accepted ray
    hit_t pending_hits [$];
    int   error_count = 0;
    int   burst_left  = 0;

    // Register shadows the predictor works from
    logic [RADIUS_W-1:0] cur_radius = RADIUS_RESET;
    logic [TOL_W-1:0]    cur_tol    = TOL_RESET;

    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;
    int       rx_tick = 0;

    ray_sphere_intersect_distance u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_origin_x (s_origin_x),
        .s_origin_y (s_origin_y),
        .s_origin_z (s_origin_z),
        .s_dir_x    (s_dir_x),
        .s_dir_y    (s_dir_y),
        .s_dir_z    (s_dir_z),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_hit      (m_hit),
        .m_distance (m_distance),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("tb_ray_sphere_intersect_distance: FAIL");
        $finish;
    end

    task automatic flag_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
        error_count++;
        $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    // --------------------------------------------------------------------
    // Prediction
    // --------------------------------------------------------------------

    function automatic wide_t widen(logic [31:0] v);
        return {{96{v[31]}}, v};
    endfunction

    // Integer square root, rounded down, of a non-negative value
    function automatic wide_t floor_root(wide_t n);
        wide_t res, probe;
        res   = '0;
        probe = wide_t'(1) << 124;
        while (probe > n) probe = probe >> 2;
        while (probe != 0) begin
            if (n >= res + probe) begin
                n   = n - (res + probe);
                res = (res >> 1) + probe;
            end else begin
                res = res >> 1;
            end
            probe = probe >> 2;
        end
        return res;
    endfunction

    // Nearest intersection ahead of the ray, in Q18.16, for the given registers
    function automatic hit_t nearest_hit(ray_t ray, logic [RADIUS_W-1:0] radius,
                                         logic [TOL_W-1:0] tol);
        wide_t px, py, pz, nx, ny, nz, rad, c, mag, b, b16, d, s, near, far, t;
        hit_t  res;
        res = NO_HIT;
        px  = widen(ray.ox);
        py  = widen(ray.oy);
        pz  = widen(ray.oz);
        nx  = widen(ray.dx);
        ny  = widen(ray.dy);
        nz  = widen(ray.dz);
        rad = {{(128 - RADIUS_W){1'b0}}, radius};

        // c = |p|^2 - R^2 in Q.32; a small |c| means the origin sits on the shell
        c   = px * px + py * py + pz * pz - rad * rad;
        mag = (c < 0) ? -c : c;
        if (mag <= {{(128 - TOL_W){1'b0}}, tol}) return res;

        // b = p.n, rounded half up to Q.16
        b   = px * nx + py * ny + pz * nz;
        b16 = (b + ROUND_HALF) >>> DIR_FRAC;
        d   = b16 * b16 - c;
        if (d < 0) return res;

        s    = floor_root(d);
        near = -b16 - s;
        far  = -b16 + s;
        if (near > 0) t = near;
        else if (far > 0) t = far;
        else return res;

        res.hit      = 1'b1;
        res.distance = (t > DIST_CAP) ? {DIST_W{1'b1}} : t[DIST_W-1:0];
        return res;
    endfunction

    // --------------------------------------------------------------------
    // Ray generation
    // --------------------------------------------------------------------

    function automatic real rand_pm1();
        return ($urandom / 4294967296.0) * 2.0 - 1.0;
    endfunction

    function automatic void normalize(inout real x, inout real y, inout real z);
        real norm;
        norm = $sqrt(x * x + y * y + z * z);
        if (norm < 1.0e-9) begin
            x = 1.0;
            y = 0.0;
            z = 0.0;
        end else begin
            x = x / norm;
            y = y / norm;
            z = z / norm;
        end
    endfunction

    function automatic logic [31:0] to_q16(real v);
        real s;
        s = v * 65536.0;
        if (s > 2147483647.0) s = 2147483647.0;
        else if (s < -2147483648.0) s = -2147483648.0;
        return $rtoi(s);
    endfunction

    function automatic logic [31:0] to_q30(real v);
        real s;
        s = v * 1073741824.0;
        if (s > 1073741824.0) s = 1073741824.0;
        else if (s < -1073741824.0) s = -1073741824.0;
        return $rtoi(s);
    endfunction

    function automatic logic [31:0] extreme_value(bit is_dir);
        case ($urandom_range(0, 3))
            0:       return is_dir ? D_ONE : P_MAX;
            1:       return is_dir ? D_NEG : P_MIN;
            2:       return ZERO;
            default: return ALL1;
        endcase
    endfunction

    // Mostly rays aimed at the sphere from all distances, some away from it,
    // some sitting on the shell, then free rays, extremes and raw noise
    function automatic ray_t random_ray(logic [RADIUS_W-1:0] radius);
        ray_t        ray;
        real         base, reach, gain, ox, oy, oz, ux, uy, uz, ex, ey, ez;
        int unsigned pick;
        logic [31:0] on_axis, off_axis;
        ray  = '0;
        base = (radius != 0) ? radius / 65536.0 : 1.0;
        pick = $urandom_range(0, 99);
        ux   = rand_pm1();
        uy   = rand_pm1();
        uz   = rand_pm1();
        normalize(ux, uy, uz);

        if (pick < 55) begin
            case ($urandom_range(0, 4))
                0:       reach = 0.3;
                1:       reach = 0.95;
                2:       reach = 1.05;
                3:       reach = 4.0;
                default: reach = 200.0;
            endcase
            ox = ux * base * reach;
            oy = uy * base * reach;
            oz = uz * base * reach;
            // aim at a random point well inside the sphere
            ex = rand_pm1() * 0.55 * base - ox;
            ey = rand_pm1() * 0.55 * base - oy;
            ez = rand_pm1() * 0.55 * base - oz;
            normalize(ex, ey, ez);
            gain = ($urandom_range(0, 7) == 0) ? 0.3 + $urandom_range(0, 1000) / 1500.0 : 1.0;
            if ($urandom_range(0, 3) == 0) gain = -gain;
            ray.ox = to_q16(ox);
            ray.oy = to_q16(oy);
            ray.oz = to_q16(oz);
            ray.dx = to_q30(ex * gain);
            ray.dy = to_q30(ey * gain);
            ray.dz = to_q30(ez * gain);
        end else if (pick < 65) begin
            // on an axis at the radius, nudged a few lsb off the shell
            on_axis  = {1'b0, radius};
            off_axis = $urandom_range(0, 16);
            if ($urandom_range(0, 1) == 1) on_axis = -on_axis;
            if ($urandom_range(0, 1) == 1) off_axis = -off_axis;
            case ($urandom_range(0, 2))
                0: begin
                    ray.ox = on_axis;
                    ray.oy = off_axis;
                end
                1: begin
                    ray.oy = on_axis;
                    ray.oz = off_axis;
                end
                default: begin
                    ray.oz = on_axis;
                    ray.ox = off_axis;
                end
            endcase
            ray.dx = to_q30(ux);
            ray.dy = to_q30(uy);
            ray.dz = to_q30(uz);
        end else if (pick < 80) begin
            ray.ox = to_q16(rand_pm1() * 4.0 * base);
            ray.oy = to_q16(rand_pm1() * 4.0 * base);
            ray.oz = to_q16(rand_pm1() * 4.0 * base);
            ray.dx = to_q30(ux);
            ray.dy = to_q30(uy);
            ray.dz = to_q30(uz);
        end else if (pick < 88) begin
            ray.ox = extreme_value(1'b0);
            ray.oy = extreme_value(1'b0);
            ray.oz = extreme_value(1'b0);
            ray.dx = extreme_value(1'b1);
            ray.dy = extreme_value(1'b1);
            ray.dz = extreme_value(1'b1);
        end else begin
            ray.ox = $urandom;
            ray.oy = $urandom;
            ray.oz = $urandom;
            ray.dx = $urandom_range(0, 32'h8000_0000) - D_ONE;
            ray.dy = $urandom_range(0, 32'h8000_0000) - D_ONE;
            ray.dz = $urandom_range(0, 32'h8000_0000) - D_ONE;
        end
        return ray;
    endfunction

    // --------------------------------------------------------------------
    // Drivers; every task is entered and left at a falling edge
    // --------------------------------------------------------------------

    // Offer one ray; the sender runs in bursts, mostly with idle gaps between them
    task automatic send_ray(input ray_t ray, input hit_t want);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_valid    <= 1'b1;
        s_origin_x <= ray.ox;
        s_origin_y <= ray.oy;
        s_origin_z <= ray.oz;
        s_dir_x    <= ray.dx;
        s_dir_y    <= ray.dy;
        s_dir_z    <= ray.dz;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_hits.push_back(want);
        burst_left--;
        @(negedge aclk);
    endtask

    // Drop valid and hold until every expected word has come out
    task automatic drain_results();
        s_valid    <= 1'b0;
        burst_left = 0;
        while (pending_hits.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Write a register over APB, then read it back
    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
        logic [APB_DATA_W-1:0] readback;
        if (addr == ADDR_RADIUS) begin
            cur_radius = data[RADIUS_W-1:0];
            readback   = {1'b0, cur_radius};
        end else begin
            cur_tol  = data;
            readback = cur_tol;
        end
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= readback;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== readback) flag_mismatch("register readback", prdata, readback);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    // --------------------------------------------------------------------
    // Receiver: switch between stall patterns every so often
    // --------------------------------------------------------------------
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 4));
            rx_left = $urandom_range(20, 150);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN:     m_ready <= 1'b1;
            RX_BUSY:     m_ready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE:   m_ready <= ($urandom_range(0, 3) == 0);
            RX_PERIODIC: m_ready <= ((rx_tick % 7) < 3);
            default:     m_ready <= (rx_left < 4);   // long stall, release at the end
        endcase
    end

    // --------------------------------------------------------------------
    // Result checker: compare each word leaving the block with the oldest
    // expectation, field by field
    // --------------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        hit_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_hits.size() == 0) begin
                flag_mismatch("unexpected word, distance", m_distance, 0);
            end else begin
                want = pending_hits.pop_front();
                if (m_hit !== want.hit) flag_mismatch("hit", m_hit, want.hit);
                if (m_distance !== want.distance)
                    flag_mismatch("distance", m_distance, want.distance);
            end
        end
    end

    // --------------------------------------------------------------------
    // Main sequence
    // --------------------------------------------------------------------
    initial begin
        ray_t ray;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed rays against the reset registers
        for (int i = 0; i < N_DIRECTED; i++) begin
            ray = directed_rows[i].ray;
            send_ray(ray, directed_rows[i].known ? directed_rows[i].want
                                                 : nearest_hit(ray, cur_radius, cur_tol));
        end

        // Random phases, each with its own register setting; registers change
        // only once the pipeline is empty
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            case (ph)
                0: ;    // keep the reset values
                1: begin
                    write_reg(ADDR_RADIUS, 32'd0);
                    write_reg(ADDR_TOLERANCE, 32'd0);
                end
                2: begin
                    write_reg(ADDR_RADIUS, 32'h7FFF_FFFF);
                    write_reg(ADDR_TOLERANCE, 32'hFFFF_FFFF);
                end
                3: begin
                    write_reg(ADDR_RADIUS, $urandom_range(32'h0000_4000, 32'h0400_0000));
                    write_reg(ADDR_TOLERANCE, $urandom);
                end
                4: begin
                    write_reg(ADDR_RADIUS, 32'h0064_0000);     // 100.0
                    write_reg(ADDR_TOLERANCE, 32'h0010_0000);
                end
                default: begin
                    write_reg(ADDR_RADIUS, RADIUS_RESET);
                    write_reg(ADDR_TOLERANCE, TOL_RESET);
                end
            endcase
            for (int n = 0; n < RAYS_PER_PHASE; n++) begin
                // once mid-phase, hold the sender until the pipeline runs dry
                if (ph == 3 && n == RAYS_PER_PHASE / 2) drain_results();
                ray = random_ray(cur_radius);
                send_ray(ray, nearest_hit(ray, cur_radius, cur_tol));
            end
        end

        // Wait for the last words, then give stray ones a chance to show up
        drain_results();
        repeat (PIPE_LATENCY + 16) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb_ray_sphere_intersect_distance: PASS");
        end else begin
            $display("tb_ray_sphere_intersect_distance: FAIL");
        end
        $finish;
    end

endmodule
